@@ sv/bda_pkg.sv @@
// Shared types and constants for the button debounce and auto-repeat block.
// Holds the per-button record, phase and controller encodings and register indexes.
// No dependencies.
package bda_pkg;

  localparam int LINES_DEF     = 4;
  localparam int DPL_DEF       = 16;
  localparam int BUTTONS_DEF   = 4;
  localparam int MAX_BURST_DEF = 8;
  localparam int MAX_OUT       = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IVL_W      = 40;
  localparam int DIV_STEPS  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_IVL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCELERATE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMM_OK_MASK  = 3'd5;

  localparam logic [15:0] PRESS_DELAY_RST   = 16'd0;
  localparam logic [15:0] RELEASE_DELAY_RST = 16'd0;
  localparam logic [31:0] FIRST_REPEAT_RST  = 32'd1000000;
  localparam logic [25:0] REPEAT_IVL_RST    = 26'd50000000;
  localparam logic        ACCELERATE_RST    = 1'b0;
  localparam logic [7:0]  COMM_OK_MASK_RST  = 8'd32;

  // Division by 103: ceil(2^32 / 103) and floor(2^20 / 103); 2^20 mod 103 is 36.
  localparam logic [25:0] DIV_RECIP = 26'd41698712;
  localparam logic [13:0] DIV_HI_Q  = 14'd10180;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_PRESSING  = 2'd1,
    PH_HELD      = 2'd2,
    PH_RELEASING = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_SUB,
    ST_SCALE,
    ST_EVAL,
    ST_DIV,
    ST_WB,
    ST_EMIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic signed [IVL_W-1:0] iv;
    logic                    rf;
    logic [31:0]             lr;
    logic [31:0]             pt;
    phase_e                  ph;
  } rec_t;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic eval;
    logic div_step;
    logic wb;
    logic push;
    logic adv;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    logic clr_last;
    logic need_div;
    logic div_done;
    logic has_emit;
    logic cnt_last;
    logic more;
    logic can_push;
    logic pend_v;
  } sts_t;

endpackage

@@ sv/bda_ctrl.sv @@
// Controller state machine: clearing pass, per-button walk, division wait and event pushes.
// Depends on bda_pkg.
module bda_ctrl import bda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output state_e state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_ok) state_d = ST_RD;
        end
      end
      ST_RD:    state_d = ST_SUB;
      ST_SUB:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_EVAL;
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = sts_i.need_div ? ST_DIV : ST_WB;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_WB;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        if (sts_i.has_emit) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.adv = 1'b1;
          state_d = sts_i.more ? ST_RD : ST_FIN;
        end
      end
      ST_EMIT: begin
        if (sts_i.can_push) begin
          cmd_o.push = 1'b1;
          if (sts_i.cnt_last) begin
            cmd_o.adv = 1'b1;
            state_d = sts_i.more ? ST_RD : ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (sts_i.can_push) begin
          cmd_o.fin = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign state_o = state_q;

endmodule

@@ sv/bda_dp.sv @@
// Datapath: configuration registers, per-button state memory, time compares,
// constant divider for acceleration, pending event and output register. Depends on bda_pkg.
module bda_dp import bda_pkg::*; #(
  parameter int LINES     = LINES_DEF,
  parameter int DPL       = DPL_DEF,
  parameter int BUTTONS   = BUTTONS_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [63:0]           in_data_i,
  input  logic                  in_norep_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_data_o,
  output logic                  out_cause_o,
  output logic                  out_last_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  localparam int SLOTS  = LINES * DPL * BUTTONS;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BTN_W  = $clog2(BUTTONS + 1);
  localparam int CNT_W  = $clog2(MAX_BURST + 1);
  localparam int EVN_W  = $clog2(MAX_OUT + 1);
  localparam int DCNT_W = $clog2(DIV_STEPS);

  // Configuration registers.
  logic [15:0] pd_q, rld_q;
  logic [31:0] frd_q;
  logic [25:0] ri_q;
  logic        acc_q;
  logic [7:0]  mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_q   <= PRESS_DELAY_RST;
      rld_q  <= RELEASE_DELAY_RST;
      frd_q  <= FIRST_REPEAT_RST;
      ri_q   <= REPEAT_IVL_RST;
      acc_q  <= ACCELERATE_RST;
      mask_q <= COMM_OK_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRESS_DELAY:   pd_q   <= cfg_data_i[15:0];
        REG_RELEASE_DELAY: rld_q  <= cfg_data_i[15:0];
        REG_FIRST_REPEAT:  frd_q  <= cfg_data_i;
        REG_REPEAT_IVL:    ri_q   <= cfg_data_i[25:0];
        REG_ACCELERATE:    acc_q  <= cfg_data_i[0];
        REG_COMM_OK_MASK:  mask_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Poll fields.
  logic [1:0]  in_ln;
  logic [3:0]  in_dp;
  logic [7:0]  in_st, in_chk, st_eff;
  logic [31:0] in_now;
  logic [2:0]  in_nb;
  logic [BTN_W-1:0] nb_eff;
  logic        sel_ok;

  assign in_ln  = in_data_i[1:0];
  assign in_dp  = in_data_i[5:2];
  assign in_st  = in_data_i[13:6];
  assign in_chk = in_data_i[21:14];
  assign in_now = in_data_i[53:22];
  assign in_nb  = in_data_i[56:54];
  assign st_eff = (~in_st == in_chk) ? in_st : 8'd0;
  assign nb_eff = (int'(in_nb) > BUTTONS) ? BTN_W'(BUTTONS) : BTN_W'(in_nb);
  assign sel_ok = (int'(in_ln) < LINES) && (int'(in_dp) < DPL);

  logic [1:0]       ln_q;
  logic [3:0]       dp_q;
  logic [7:0]       st_q;
  logic [31:0]      now_q;
  logic             norep_q;
  logic [BTN_W-1:0] nb_q, btn_q;
  logic [ADDR_W-1:0] base_q, addr, clr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ln_q    <= in_ln;
      dp_q    <= in_dp;
      st_q    <= st_eff;
      now_q   <= in_now;
      norep_q <= in_norep_i;
      nb_q    <= nb_eff;
      base_q  <= ADDR_W'((int'(in_ln) * DPL + int'(in_dp)) * BUTTONS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.accept) btn_q <= '0;
      else if (cmd_i.adv) btn_q <= btn_q + BTN_W'(1);
      if (cmd_i.clr_wr) clr_q <= clr_q + ADDR_W'(1);
    end
  end

  assign addr = base_q + ADDR_W'(btn_q);

  // State memory with one write and one registered read port.
  rec_t mem_q [SLOTS];
  rec_t rd_q, wrec;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) mem_q[clr_q] <= '0;
    else if (cmd_i.wb) mem_q[addr] <= wrec;
    rd_q <= mem_q[addr];
  end

  // Time differences, then scaled forms for the interval compare.
  logic [31:0] d_pt_q, d_lr_q;
  logic [IVL_W-1:0] scaled_q, ivx_q, ivm1, d_lr_w, rep100;

  assign d_lr_w = IVL_W'(d_lr_q);
  assign ivm1   = rd_q.iv - IVL_W'(1);
  assign rep100 = (IVL_W'(ri_q) << 6) + (IVL_W'(ri_q) << 5) + (IVL_W'(ri_q) << 2);

  always_ff @(posedge clk_i) begin
    d_pt_q   <= now_q - rd_q.pt;
    d_lr_q   <= now_q - rd_q.lr;
    // floor(iv / 100) <= d exactly when iv <= 100 * d + 99.
    scaled_q <= (d_lr_w << 6) + (d_lr_w << 5) + (d_lr_w << 2) + IVL_W'(99);
    ivx_q    <= (ivm1 << 6) + (ivm1 << 5) + (ivm1 << 2);
  end

  // Per-button evaluation.
  logic [7:0] st_sh;
  logic       pressed, is_two, rep_en, press_ok, held_ok;
  logic [IVL_W-1:0] neg_iv;
  logic [CNT_W-1:0] burst, e_cnt;
  logic       e_cause, e_div;
  rec_t       nrec;

  assign st_sh    = st_q >> btn_q;
  assign pressed  = st_sh[0];
  assign is_two   = (int'(btn_q) == 2);
  assign rep_en   = !norep_q && !is_two && (frd_q != 32'd0);
  assign press_ok = ((rd_q.ph == PH_IDLE) ? 32'd0 : d_pt_q) >= 32'(pd_q);
  assign held_ok  = rd_q.iv[IVL_W-1] || (rd_q.iv <= scaled_q);
  assign neg_iv   = -rd_q.iv;
  assign burst    = !rd_q.iv[IVL_W-1] ? CNT_W'(1) :
                    (neg_iv >= IVL_W'(MAX_BURST - 1)) ? CNT_W'(MAX_BURST) :
                    CNT_W'(neg_iv + IVL_W'(1));

  always_comb begin
    nrec    = rd_q;
    e_cnt   = '0;
    e_cause = 1'b0;
    e_div   = 1'b0;
    if (pressed) begin
      case (rd_q.ph)
        PH_IDLE, PH_PRESSING: begin
          if (press_ok) begin
            nrec.ph = PH_HELD;
            nrec.pt = now_q;
            nrec.lr = now_q;
            nrec.rf = 1'b0;
            e_cnt   = CNT_W'(1);
          end else if (rd_q.ph == PH_IDLE) begin
            nrec.ph = PH_PRESSING;
            nrec.pt = now_q;
          end
        end
        PH_HELD: begin
          if (rep_en) begin
            if (rd_q.rf) begin
              if (held_ok) begin
                e_cnt   = burst;
                e_cause = 1'b1;
                nrec.lr = now_q;
                if (acc_q) begin
                  // A zero interval turns into -1, and -1 scaled by 103/100 stays -1,
                  // so -1 is the only negative interval that ever occurs.
                  if (rd_q.iv == '0 || rd_q.iv[IVL_W-1]) nrec.iv = '1;
                  else e_div = 1'b1;
                end
              end
            end else if (d_pt_q > frd_q) begin
              e_cnt   = CNT_W'(1);
              e_cause = 1'b1;
              nrec.iv = rep100;
              nrec.rf = 1'b1;
              nrec.lr = now_q;
            end
          end
        end
        default: begin
          nrec.ph = PH_HELD;
          nrec.pt = now_q;
        end
      endcase
    end else begin
      case (rd_q.ph)
        PH_PRESSING: begin
          nrec.ph = PH_IDLE;
          nrec.pt = now_q;
        end
        PH_HELD: begin
          nrec.ph = PH_RELEASING;
          nrec.pt = now_q;
        end
        PH_RELEASING: begin
          if (d_pt_q >= 32'(rld_q)) begin
            nrec.ph = PH_IDLE;
            nrec.pt = now_q;
          end
        end
        default: ;
      endcase
    end
  end

  rec_t nrec_q;
  logic e_cause_q, do_div_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      nrec_q    <= nrec;
      e_cause_q <= e_cause;
      do_div_q  <= e_div;
    end
  end

  // Division of x = (iv - 1) * 100 by 103 in two steps. With x = a * 2^20 + b and
  // 2^20 = 103 * 10180 + 36, x / 103 = a * 10180 + (36 * a + b) / 103. The small
  // term is divided by multiplying with ceil(2^32 / 103), exact below 2^26.
  logic [IVL_W-1:0]  quo_q, x_q, hi_q;
  logic [25:0]       y_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [19:0]       div_a, div_b;
  logic [51:0]       prod;

  assign div_a = x_q[39:20];
  assign div_b = x_q[19:0];
  assign prod  = {26'd0, y_q} * {26'd0, DIV_RECIP};

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      x_q    <= ivx_q;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dcnt_q == '0) begin
        y_q  <= (26'(div_a) << 5) + (26'(div_a) << 2) + 26'(div_b);
        hi_q <= {20'd0, div_a} * {26'd0, DIV_HI_Q};
      end else begin
        quo_q <= hi_q + IVL_W'(prod[51:32]);
      end
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
  end

  always_comb begin
    wrec = nrec_q;
    if (do_div_q) wrec.iv = quo_q;
  end

  // One event is held back so that the final event of a poll can carry the last flag.
  logic             pend_v_q, out_v_q, out_free, room, out_ld;
  logic [1:0]       pend_btn_q;
  logic             pend_cause_q;
  logic [EVN_W-1:0] evn_q;
  logic [1:0]       o_ln_q, o_btn_q;
  logic [3:0]       o_dp_q;
  logic             o_cause_q, o_last_q;

  assign out_free = !out_v_q || out_ready_i;
  assign room     = int'(evn_q) < MAX_OUT;
  assign out_ld   = pend_v_q && ((cmd_i.push && room) || cmd_i.fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      evn_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.accept) evn_q <= '0;
      else if (cmd_i.push && room) evn_q <= evn_q + EVN_W'(1);
      if (cmd_i.push && room) pend_v_q <= 1'b1;
      else if (cmd_i.fin) pend_v_q <= 1'b0;
      if (out_ld) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      if (cmd_i.eval) cnt_q <= e_cnt;
      else if (cmd_i.push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && room) begin
      pend_btn_q   <= 2'(btn_q);
      pend_cause_q <= e_cause_q;
    end
    if (out_ld) begin
      o_ln_q    <= ln_q;
      o_dp_q    <= dp_q;
      o_btn_q   <= pend_btn_q;
      o_cause_q <= pend_cause_q;
      o_last_q  <= cmd_i.fin;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = {o_btn_q, o_dp_q, o_ln_q};
  assign out_cause_o = o_cause_q;
  assign out_last_o  = o_last_q;

  always_comb begin
    sts_o          = '0;
    sts_o.in_ok    = sel_ok && ((st_eff & mask_q) != 8'd0) && (nb_eff != '0);
    sts_o.clr_last = (clr_q == ADDR_W'(SLOTS - 1));
    sts_o.need_div = e_div;
    sts_o.div_done = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
    sts_o.has_emit = (cnt_q != '0);
    sts_o.cnt_last = (cnt_q == CNT_W'(1));
    sts_o.more     = ({1'b0, btn_q} + (BTN_W + 1)'(1)) < {1'b0, nb_q};
    sts_o.can_push = !pend_v_q || out_free;
    sts_o.pend_v   = pend_v_q;
  end

endmodule

@@ sv/button_debounce_autorepeat_top.sv @@
// A poll is accepted, then each button is read, its time differences taken and scaled, it is
// evaluated, divided when its repeat interval shrinks, written back and its key events pushed;
// then the poll finishes. The walk is sequential over buttons through one state memory port;
// one poll at a time. Reset clears, in one pass, the LINES*DISPLAYS_PER_LINE*BUTTONS slots
// (256 by default) during which no item is accepted; configuration is taken throughout.
module button_debounce_autorepeat_top import bda_pkg::*; #(
  parameter int LINES             = LINES_DEF,
  parameter int DISPLAYS_PER_LINE = DPL_DEF,
  parameter int BUTTONS           = BUTTONS_DEF,
  parameter int MAX_BURST         = MAX_BURST_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // line_index, display_index, status_byte, check_byte, now_time, button_count, zero pad
  input  logic [63:0]           s_axis_tdata,
  // no_repeat
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // key_line, key_display, key_button
  output logic [7:0]            m_axis_tdata,
  // key_cause
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  cmd_t   cmd;
  sts_t   sts;
  state_e state;

  bda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  bda_dp #(
    .LINES     (LINES),
    .DPL       (DISPLAYS_PER_LINE),
    .BUTTONS   (BUTTONS),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_norep_i  (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_cause_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // A new poll may only start once the held-back event of the previous one is out.
  a_no_pend_at_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !sts.pend_v) else $error("pending event left at poll start");

  a_push_has_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> sts.can_push) else $error("event pushed with no space");

  a_out_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.push || cmd.fin)) else $error("output without push");

  a_no_ready_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_CLEAR) |-> !s_axis_tready && !m_axis_tvalid)
    else $error("activity during clearing pass");

endmodule

@@ bench/button_debounce_autorepeat_top_tb.sv @@
// Self-checking testbench for button_debounce_autorepeat_top: sends display polls, predicts
// key events with an internal per-button state machine and checks every item out of the block.
// Depends on bda_pkg and the top-level RTL.
module button_debounce_autorepeat_top_tb;
  import bda_pkg::*;

  localparam int SLOT_CNT   = LINES_DEF * DPL_DEF * BUTTONS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [1:0]  line;
    logic [3:0]  disp;
    logic [7:0]  status;
    logic [7:0]  check;
    logic [31:0] now;
    logic [2:0]  count;
    logic        norep;
  } poll_t;

  typedef struct {
    logic [1:0] line;
    logic [3:0] disp;
    logic [1:0] button;
    logic       cause;
    logic       last;
  } key_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  button_debounce_autorepeat_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the configuration registers.
  logic [15:0] press_dly;
  logic [15:0] release_dly;
  logic [31:0] first_rpt;
  logic [25:0] rpt_ivl;
  logic        accel;
  logic [7:0]  comm_mask;

  // Shadow of the per-button state.
  phase_e      btn_phase[SLOT_CNT];
  logic [31:0] phase_at[SLOT_CNT];
  logic [31:0] repeat_at[SLOT_CNT];
  logic        repeated[SLOT_CNT];
  longint      ivl_x100[SLOT_CNT];

  poll_t polls_pending[$];
  key_t  keys_expected[$];
  poll_t poll_cur;
  int    errors = 0;
  int    idle_cycles = 0;
  bit    quiet = 1'b0;
  int    src_gap = 0;
  int    snk_gap = 0;
  logic [31:0] clock_cs;

  function automatic void push_key(ref key_t evs[$], input poll_t p, input int b,
                                   input logic cause);
    key_t k;
    if (evs.size() >= MAX_OUT) return;
    k.line = p.line;
    k.disp = p.disp;
    k.button = 2'(b);
    k.cause = cause;
    k.last = 1'b0;
    evs.push_back(k);
  endfunction

  function automatic void auto_repeat(ref key_t evs[$], input poll_t p, input int s,
                                      input int b);
    longint      iv;
    logic [31:0] need;
    logic [31:0] dt;
    int          cnt;
    iv = ivl_x100[s];
    if (repeated[s]) begin
      need = (iv < 0) ? 32'd0 : 32'(iv / 100);
      dt = p.now - repeat_at[s];
      if (dt >= need) begin
        cnt = 1;
        if (iv < 0) cnt = (-iv >= MAX_BURST_DEF - 1) ? MAX_BURST_DEF : int'(-iv) + 1;
        repeat (cnt) push_key(evs, p, b, 1'b1);
        repeat_at[s] = p.now;
        if (accel) begin
          if (iv == 0) iv = -1;
          if (iv >= 0) iv = ((iv - 1) * 100) / 103;
          else iv = (iv * 103) / 100;
          if (iv < -(longint'(1) <<< 39)) iv = -(longint'(1) <<< 39);
          ivl_x100[s] = iv;
        end
      end
    end else begin
      dt = p.now - phase_at[s];
      if (dt > first_rpt) begin
        push_key(evs, p, b, 1'b1);
        ivl_x100[s] = longint'(rpt_ivl) * 100;
        repeated[s] = 1'b1;
        repeat_at[s] = p.now;
      end
    end
  endfunction

  // Advances the shadow state by one poll and queues the key events it causes.
  function automatic void predict_keys(poll_t p);
    key_t        evs[$];
    logic [7:0]  st;
    logic [31:0] dt;
    int          nbtn;
    int          s;
    st = (~p.status == p.check) ? p.status : 8'h00;
    if ((st & comm_mask) == 0) return;
    nbtn = (p.count > BUTTONS_DEF) ? BUTTONS_DEF : int'(p.count);
    for (int b = 0; b < nbtn; b++) begin
      s = (int'(p.line) * DPL_DEF + int'(p.disp)) * BUTTONS_DEF + b;
      dt = p.now - phase_at[s];
      if (st[b]) begin
        if (btn_phase[s] == PH_IDLE) begin
          btn_phase[s] = PH_PRESSING;
          phase_at[s] = p.now;
          dt = 32'd0;
        end
        if (btn_phase[s] == PH_PRESSING) begin
          if (dt >= press_dly) begin
            btn_phase[s] = PH_HELD;
            phase_at[s] = p.now;
            repeat_at[s] = p.now;
            repeated[s] = 1'b0;
            push_key(evs, p, b, 1'b0);
          end
        end else if (btn_phase[s] == PH_HELD) begin
          if (!p.norep && b != 2 && first_rpt != 0) auto_repeat(evs, p, s, b);
        end else begin
          btn_phase[s] = PH_HELD;
          phase_at[s] = p.now;
        end
      end else if (btn_phase[s] == PH_PRESSING) begin
        btn_phase[s] = PH_IDLE;
        phase_at[s] = p.now;
      end else if (btn_phase[s] == PH_HELD) begin
        btn_phase[s] = PH_RELEASING;
        phase_at[s] = p.now;
      end else if (btn_phase[s] == PH_RELEASING && dt >= release_dly) begin
        btn_phase[s] = PH_IDLE;
        phase_at[s] = p.now;
      end
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) keys_expected.push_back(evs[i]);
  endfunction

  // Poll driver.
  always @(posedge clk_i) begin
    logic acc;
    logic nv;
    acc = s_axis_tvalid && s_axis_tready;
    if (acc) begin
      predict_keys(poll_cur);
      void'(polls_pending.pop_front());
    end
    if (!s_axis_tvalid || acc) begin
      nv = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (polls_pending.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 2);
        end else begin
          nv = 1'b1;
          poll_cur = polls_pending[0];
          s_axis_tdata <= {7'd0, poll_cur.count, poll_cur.now, poll_cur.check,
                           poll_cur.status, poll_cur.disp, poll_cur.line};
          s_axis_tuser <= poll_cur.norep;
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // Key event monitor and watchdog.
  always @(posedge clk_i) begin
    key_t k;
    if (m_axis_tvalid && m_axis_tready) begin
      if (keys_expected.size() == 0) begin
        $error("unexpected key event %h", m_axis_tdata);
        errors++;
      end else begin
        k = keys_expected.pop_front();
        if (m_axis_tdata[1:0] !== k.line) begin
          $error("key_line: expected %0d, got %0d", k.line, m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[5:2] !== k.disp) begin
          $error("key_display: expected %0d, got %0d", k.disp, m_axis_tdata[5:2]);
          errors++;
        end
        if (m_axis_tdata[7:6] !== k.button) begin
          $error("key_button: expected %0d, got %0d", k.button, m_axis_tdata[7:6]);
          errors++;
        end
        if (m_axis_tuser !== k.cause) begin
          $error("key_cause: expected %0d, got %0d", k.cause, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== k.last) begin
          $error("last_event: expected %0d, got %0d", k.last, m_axis_tlast);
          errors++;
        end
      end
    end
    if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      snk_gap = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_PRESS_DELAY:   press_dly = val[15:0];
      REG_RELEASE_DELAY: release_dly = val[15:0];
      REG_FIRST_REPEAT:  first_rpt = val;
      REG_REPEAT_IVL:    rpt_ivl = val[25:0];
      REG_ACCELERATE:    accel = val[0];
      REG_COMM_OK_MASK:  comm_mask = val[7:0];
      default: ;
    endcase
  endtask

  task automatic reg_write_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_poll(logic [1:0] ln, logic [3:0] dp, logic [7:0] st, bit good,
                           logic [31:0] now, logic [2:0] cnt, logic nr);
    poll_t p;
    p.line = ln;
    p.disp = dp;
    p.status = st;
    p.check = good ? ~st : 8'($urandom);
    p.now = now;
    p.count = cnt;
    p.norep = nr;
    polls_pending.push_back(p);
  endtask

  function automatic logic [7:0] comm_bit();
    return comm_mask & (~comm_mask + 8'd1);
  endfunction

  // A well-formed press, hold and release of a random button set on one display.
  task automatic press_sequence(int step);
    logic [1:0] ln;
    logic [3:0] dp;
    logic [3:0] held;
    logic [7:0] upper;
    logic       nr;
    int         n;
    ln = 2'($urandom);
    dp = 4'($urandom_range(0, 3));
    held = 4'($urandom_range(1, 15));
    nr = ($urandom_range(0, 5) == 0);
    n = $urandom_range(3, 8);
    for (int i = 0; i < n + 3; i++) begin
      clock_cs += $urandom_range(0, step);
      upper = 8'($urandom) & 8'hf0;
      if (i < n) begin
        if ($urandom_range(0, 7) == 0) held ^= 4'(1 << $urandom_range(0, 3));
        send_poll(ln, dp, upper | comm_bit() | held, 1'b1, clock_cs, 3'd4, nr);
      end else begin
        send_poll(ln, dp, (upper | comm_bit()) & ~8'h0f, 1'b1, clock_cs, 3'd4, nr);
      end
    end
  endtask

  task automatic noise_poll();
    send_poll(2'($urandom), 4'($urandom), 8'($urandom), $urandom_range(0, 3) != 0,
              $urandom, 3'($urandom), 1'($urandom));
  endtask

  // Lets every queued poll through and waits until the block has gone quiet.
  task automatic settle();
    while (polls_pending.size() != 0 || keys_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(int seqs, int step, int noise);
    for (int i = 0; i < seqs; i++) begin
      press_sequence(step);
      repeat ($urandom_range(0, noise)) noise_poll();
    end
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_PRESS_DELAY;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    press_dly = PRESS_DELAY_RST;
    release_dly = RELEASE_DELAY_RST;
    first_rpt = FIRST_REPEAT_RST;
    rpt_ivl = REPEAT_IVL_RST;
    accel = ACCELERATE_RST;
    comm_mask = COMM_OK_MASK_RST;
    for (int i = 0; i < SLOT_CNT; i++) begin
      btn_phase[i] = PH_IDLE;
      phase_at[i] = '0;
      repeat_at[i] = '0;
      repeated[i] = 1'b0;
      ivl_x100[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed polls at reset settings: checks, counts, selectors and time extremes.
    send_poll(2'd0, 4'd0, 8'h21, 1'b1, 32'd0, 3'd4, 1'b0);
    send_poll(2'd0, 4'd0, 8'h01, 1'b1, 32'd5, 3'd4, 1'b0);
    send_poll(2'd0, 4'd0, 8'h21, 1'b0, 32'd6, 3'd4, 1'b0);
    send_poll(2'd0, 4'd0, 8'h20, 1'b1, 32'd7, 3'd4, 1'b0);
    send_poll(2'd3, 4'd15, 8'hff, 1'b1, 32'hffff_ffff, 3'd7, 1'b1);
    send_poll(2'd3, 4'd15, 8'hff, 1'b1, 32'd2_000_000, 3'd7, 1'b0);
    send_poll(2'd3, 4'd15, 8'hff, 1'b1, 32'd3_000_000, 3'd7, 1'b0);
    send_poll(2'd3, 4'd15, 8'hf0, 1'b1, 32'd3_000_001, 3'd5, 1'b0);
    send_poll(2'd2, 4'd9, 8'h2f, 1'b1, 32'd100, 3'd0, 1'b0);
    send_poll(2'd1, 4'd6, 8'h00, 1'b1, 32'd0, 3'd4, 1'b0);
    send_poll(2'd1, 4'd6, 8'hff, 1'b0, 32'd0, 3'd4, 1'b0);
    settle();

    // Short delays, slow repeats.
    reg_write(REG_PRESS_DELAY, 32'd3);
    reg_write(REG_RELEASE_DELAY, 32'd2);
    reg_write(REG_FIRST_REPEAT, 32'd8);
    reg_write(REG_REPEAT_IVL, 32'd4);
    reg_write(REG_ACCELERATE, 32'd0);
    reg_write(REG_COMM_OK_MASK, 32'h20);
    reg_write_done();
    clock_cs = 32'd1000;
    random_phase(4, 4, 2);

    // Acceleration down into bursts, with time wrapping past zero.
    reg_write(REG_PRESS_DELAY, 32'd0);
    reg_write(REG_FIRST_REPEAT, 32'd1);
    reg_write(REG_REPEAT_IVL, 32'd3);
    reg_write(REG_ACCELERATE, 32'd1);
    reg_write(REG_COMM_OK_MASK, 32'h80);
    reg_write_done();
    clock_cs = 32'hffff_ffe0;
    random_phase(4, 3, 2);

    // Extreme delays; an empty comm mask ignores every poll.
    reg_write(REG_PRESS_DELAY, 32'hffff);
    reg_write(REG_RELEASE_DELAY, 32'hffff);
    reg_write(REG_FIRST_REPEAT, 32'hffff_ffff);
    reg_write(REG_REPEAT_IVL, 32'd50_000_000);
    reg_write(REG_COMM_OK_MASK, 32'h00);
    reg_write_done();
    repeat (10) noise_poll();
    settle();
    reg_write(REG_COMM_OK_MASK, 32'hff);
    reg_write_done();
    clock_cs = $urandom;
    random_phase(2, 40000, 3);

    // Auto-repeat disabled, then the last stretch without idling.
    reg_write(REG_PRESS_DELAY, 32'd1);
    reg_write(REG_RELEASE_DELAY, 32'd0);
    reg_write(REG_FIRST_REPEAT, 32'd0);
    reg_write(REG_COMM_OK_MASK, 32'h01);
    reg_write_done();
    random_phase(2, 3, 2);
    reg_write(REG_FIRST_REPEAT, 32'd2);
    reg_write(REG_REPEAT_IVL, 32'd0);
    reg_write(REG_COMM_OK_MASK, 32'h40);
    reg_write_done();
    quiet = 1'b1;
    random_phase(3, 2, 1);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
